// File: rtl/midi_note_band_tracker_assert.svh
// Assertion macros shared by the note band tracker RTL.
`ifndef MIDI_NOTE_BAND_TRACKER_ASSERT_SVH
`define MIDI_NOTE_BAND_TRACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MNBT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define MNBT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define MNBT_ASSERT(lbl, prop)
`define MNBT_ASSERT_NEVER(lbl, cond)
`endif

`endif

// File: rtl/mnbt_pkg.sv
// Shared constants, types and helpers of the note band tracker.
package mnbt_pkg;

  localparam int NUM_BANDS      = 12;
  localparam int NOTES_PER_BAND = 10;
  localparam int BAND_W         = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int MASK_BITS      = 12;
  localparam int MASK_USED      = (NUM_BANDS < MASK_BITS) ? NUM_BANDS : MASK_BITS;
  localparam int COUNT_W        = 8;
  localparam int EVQ_DEPTH      = 4;
  localparam int EVQ_PTR_W      = $clog2(EVQ_DEPTH);

  localparam logic [7:0] TYPE_MASK     = 8'hF0;
  localparam logic [7:0] TYPE_NOTE_ON  = 8'h90;
  localparam logic [7:0] TYPE_NOTE_OFF = 8'h80;

  typedef struct packed {
    logic              is_on;
    logic [6:0]        note;
    logic [6:0]        vel;
    logic [BAND_W-1:0] band;
  } note_evt_t;

  // Band of a note: highest band whose first note does not exceed it,
  // which also clamps to the top band.
  function automatic logic [BAND_W-1:0] band_of_note(logic [6:0] note);
    logic [BAND_W-1:0] band;
    band = '0;
    for (int b = 1; b < NUM_BANDS; b++) begin
      if (int'(note) >= b * NOTES_PER_BAND) begin
        band = BAND_W'(b);
      end
    end
    return band;
  endfunction

  function automatic logic [3:0] band_to_index(logic [BAND_W-1:0] band);
    logic [3:0] idx;
    idx = '0;
    for (int i = 0; i < 4 && i < BAND_W; i++) begin
      idx[i] = band[i];
    end
    return idx;
  endfunction

endpackage

// File: rtl/mnbt_front.sv
// Byte parser: running status, data pairing and note event classification.
module mnbt_front import mnbt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] midi_byte_i,
  input  logic       evq_full_i,
  output logic       evt_valid_o,
  output note_evt_t  evt_o
);

  logic [7:0] status_q, status_d;
  logic       idx_q, idx_d;
  logic [6:0] first_q, first_d;
  logic       byte_ok;
  logic [7:0] msg_type;

  assign byte_ok  = push_i && !evq_full_i;
  assign msg_type = status_q & TYPE_MASK;

  always_comb begin
    status_d    = status_q;
    idx_d       = idx_q;
    first_d     = first_q;
    evt_valid_o = 1'b0;
    evt_o.is_on = (msg_type == TYPE_NOTE_ON) && (midi_byte_i[6:0] != '0);
    evt_o.note  = first_q;
    evt_o.vel   = midi_byte_i[6:0];
    evt_o.band  = band_of_note(first_q);
    if (byte_ok) begin
      if (midi_byte_i[7]) begin
        status_d = midi_byte_i;
        idx_d    = 1'b0;
      end else if (status_q != '0) begin
        if (!idx_q) begin
          first_d = midi_byte_i[6:0];
          idx_d   = 1'b1;
        end else begin
          idx_d       = 1'b0;
          // drop anything that is not a note message
          evt_valid_o = (msg_type == TYPE_NOTE_ON) || (msg_type == TYPE_NOTE_OFF);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
      idx_q    <= 1'b0;
      first_q  <= '0;
    end else begin
      status_q <= status_d;
      idx_q    <= idx_d;
      first_q  <= first_d;
    end
  end

  `include "midi_note_band_tracker_assert.svh"

  `MNBT_ASSERT(a_status_clears_idx, (byte_ok && midi_byte_i[7]) |=> (idx_q == 1'b0))
  `MNBT_ASSERT_NEVER(a_evt_without_status, evt_valid_o && (status_q == '0))

endmodule

// File: rtl/mnbt_evq.sv
// Short event queue between the parser and the band counters.
module mnbt_evq import mnbt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  note_evt_t evt_i,
  output logic      full_o,
  input  logic      pop_i,
  output note_evt_t evt_o,
  output logic      empty_o
);

  note_evt_t            mem_q [EVQ_DEPTH];
  logic [EVQ_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [EVQ_PTR_W:0]   cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == (EVQ_PTR_W+1)'(EVQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign evt_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= evt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `include "midi_note_band_tracker_assert.svh"

  `MNBT_ASSERT_NEVER(a_count_range, cnt_q > (EVQ_PTR_W+1)'(EVQ_DEPTH))
  `MNBT_ASSERT_NEVER(a_push_when_full, push_i && full_o)

endmodule

// File: rtl/mnbt_back.sv
// Band counters and the result register.
module mnbt_back import mnbt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  note_evt_t            evt_i,
  input  logic                 evq_empty_i,
  output logic                 evq_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic                 is_note_on_o,
  output logic [6:0]           note_number_o,
  output logic [6:0]           note_velocity_o,
  output logic [3:0]           band_index_o,
  output logic [MASK_BITS-1:0] band_active_mask_o
);

  logic [COUNT_W-1:0]   counts_q [NUM_BANDS];
  logic [COUNT_W-1:0]   counts_d [NUM_BANDS];
  logic [COUNT_W-1:0]   cur_cnt, nxt_cnt;
  logic [MASK_BITS-1:0] mask_d, mask_q;
  logic                 valid_q, valid_d;
  logic                 on_q;
  logic [6:0]           note_q, vel_q;
  logic [3:0]           band_q;

  // take a new event when the result slot is free or being emptied
  assign evq_pop_o = !evq_empty_i && (!valid_q || pop_i);
  assign valid_d   = evq_pop_o || (valid_q && !pop_i);

  always_comb begin
    cur_cnt = counts_q[evt_i.band];
    nxt_cnt = cur_cnt;
    if (evt_i.is_on) begin
      if (cur_cnt != '1) begin
        nxt_cnt = cur_cnt + 1'b1;
      end
    end else if (cur_cnt != '0) begin
      nxt_cnt = cur_cnt - 1'b1;
    end
    counts_d = counts_q;
    if (evq_pop_o) begin
      counts_d[evt_i.band] = nxt_cnt;
    end
    mask_d = '0;
    for (int b = 0; b < MASK_USED; b++) begin
      mask_d[b] = (counts_d[b] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int b = 0; b < NUM_BANDS; b++) begin
        counts_q[b] <= '0;
      end
    end else begin
      valid_q  <= valid_d;
      counts_q <= counts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evq_pop_o) begin
      on_q   <= evt_i.is_on;
      note_q <= evt_i.note;
      vel_q  <= evt_i.vel;
      band_q <= band_to_index(evt_i.band);
      mask_q <= mask_d;
    end
  end

  assign empty_o            = !valid_q;
  assign is_note_on_o       = on_q;
  assign note_number_o      = note_q;
  assign note_velocity_o    = vel_q;
  assign band_index_o       = band_q;
  assign band_active_mask_o = mask_q;

  `include "midi_note_band_tracker_assert.svh"

  `MNBT_ASSERT(a_load_sets_valid, evq_pop_o |=> !empty_o)
  `MNBT_ASSERT_NEVER(a_pop_while_pending, evq_pop_o && valid_q && !pop_i)

endmodule

// File: rtl/midi_note_band_tracker.sv
// Top level of the MIDI note band tracker.
// Takes one MIDI byte per clock while full is low, with no gaps needed; a
// note-on or note-off message is written into the event queue at the edge
// that takes its second data byte and then loaded into the result register.
// The parser classifies bytes combinationally and hands note events through
// a four-entry queue to the band counter stage, which updates one counter
// per cycle while the result register is free or being read, and holds the
// result in an output register. full rises only when that queue is full, i.e.
// when a result waits unread behind four events; a byte may come straight after reset.
module midi_note_band_tracker import mnbt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           midi_byte_i,
  output logic                 empty,
  input  logic                 pop,
  output logic                 is_note_on_o,
  output logic [6:0]           note_number_o,
  output logic [6:0]           note_velocity_o,
  output logic [3:0]           band_index_o,
  output logic [MASK_BITS-1:0] band_active_mask_o
);

  logic      evt_valid, evq_full, evq_empty, evq_pop;
  note_evt_t evt_in, evt_out;

  assign full = evq_full;

  mnbt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .midi_byte_i (midi_byte_i),
    .evq_full_i  (evq_full),
    .evt_valid_o (evt_valid),
    .evt_o       (evt_in)
  );

  mnbt_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (evt_valid),
    .evt_i   (evt_in),
    .full_o  (evq_full),
    .pop_i   (evq_pop),
    .evt_o   (evt_out),
    .empty_o (evq_empty)
  );

  mnbt_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .evt_i              (evt_out),
    .evq_empty_i        (evq_empty),
    .evq_pop_o          (evq_pop),
    .pop_i              (pop),
    .empty_o            (empty),
    .is_note_on_o       (is_note_on_o),
    .note_number_o      (note_number_o),
    .note_velocity_o    (note_velocity_o),
    .band_index_o       (band_index_o),
    .band_active_mask_o (band_active_mask_o)
  );

endmodule

// File: dv/midi_note_band_tracker_tb.sv
// Self-checking testbench for the MIDI note band tracker: byte stream in, note events out.
module midi_note_band_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mnbt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_BYTES = 560;
  localparam int SATURATE_NOTES = 262;

  typedef struct {
    bit                 is_on;
    bit [6:0]           note;
    bit [6:0]           vel;
    bit [3:0]           band;
    bit [MASK_BITS-1:0] mask;
  } note_event_t;

  // Tracks the parser and band counters, and holds the note events still owed.
  class band_event_book;
    bit [7:0]    status_byte;
    bit          have_first;
    bit [6:0]    first_byte;
    bit [7:0]    held_notes[NUM_BANDS];
    note_event_t owed_events[$];
    int          failures;

    function new();
      status_byte = '0;
      have_first  = 1'b0;
      first_byte  = '0;
      failures    = 0;
      foreach (held_notes[b]) held_notes[b] = '0;
    endfunction

    function void take_byte(bit [7:0] midi);
      note_event_t ev;
      bit [7:0]    kind;
      int          band;
      if (midi[7]) begin
        status_byte = midi;
        have_first  = 1'b0;
        return;
      end
      if (status_byte == '0) return;
      if (!have_first) begin
        first_byte = midi[6:0];
        have_first = 1'b1;
        return;
      end
      have_first = 1'b0;
      kind = status_byte & TYPE_MASK;
      band = int'(first_byte) / NOTES_PER_BAND;
      if (band >= NUM_BANDS) band = NUM_BANDS - 1;
      if (kind == TYPE_NOTE_ON && midi[6:0] != '0) begin
        ev.is_on = 1'b1;
        if (held_notes[band] != 8'hFF) held_notes[band]++;
      end else if (kind == TYPE_NOTE_OFF || kind == TYPE_NOTE_ON) begin
        ev.is_on = 1'b0;
        if (held_notes[band] != '0) held_notes[band]--;
      end else begin
        return;
      end
      ev.note = first_byte;
      ev.vel  = midi[6:0];
      ev.band = 4'(band);
      ev.mask = '0;
      for (int b = 0; b < NUM_BANDS && b < MASK_BITS; b++)
        ev.mask[b] = (held_notes[b] != '0);
      owed_events.push_back(ev);
    endfunction

    function void check_event(note_event_t got);
      note_event_t want;
      if (owed_events.size() == 0) begin
        $display("%0t: unexpected note event, expected none, actual note %0h",
                 $time, got.note);
        failures++;
        return;
      end
      want = owed_events.pop_front();
      if (got.is_on != want.is_on) begin
        $display("%0t: is_note_on expected %0h actual %0h", $time, want.is_on, got.is_on);
        failures++;
      end
      if (got.note != want.note) begin
        $display("%0t: note_number expected %0h actual %0h", $time, want.note, got.note);
        failures++;
      end
      if (got.vel != want.vel) begin
        $display("%0t: note_velocity expected %0h actual %0h", $time, want.vel, got.vel);
        failures++;
      end
      if (got.band != want.band) begin
        $display("%0t: band_index expected %0h actual %0h", $time, want.band, got.band);
        failures++;
      end
      if (got.mask != want.mask) begin
        $display("%0t: band_active_mask expected %0h actual %0h",
                 $time, want.mask, got.mask);
        failures++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic [7:0]           midi_byte_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic                 is_note_on_o;
  logic [6:0]           note_number_o;
  logic [6:0]           note_velocity_o;
  logic [3:0]           band_index_o;
  logic [MASK_BITS-1:0] band_active_mask_o;

  band_event_book book = new();
  int  bytes_sent = 0;
  int  cycle_count = 0;
  bit  steady_sender = 1'b0;
  bit  steady_reader = 1'b0;

  midi_note_band_tracker DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .midi_byte_i        (midi_byte_i),
    .empty              (empty),
    .pop                (pop),
    .is_note_on_o       (is_note_on_o),
    .note_number_o      (note_number_o),
    .note_velocity_o    (note_velocity_o),
    .band_index_o       (band_index_o),
    .band_active_mask_o (band_active_mask_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_byte(input bit [7:0] midi);
    int gap;
    if ($urandom_range(0, 31) == 0) steady_sender = ~steady_sender;
    gap = steady_sender ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    midi_byte_i <= midi;
    do @(posedge clk_i); while (full);
    book.take_byte(midi);
    bytes_sent++;
  endtask

  task automatic send_note(input bit [7:0] status, input bit [6:0] note, input bit [6:0] vel);
    if (status[7]) send_byte(status);
    send_byte({1'b0, note});
    send_byte({1'b0, vel});
  endtask

  // Mostly well-formed messages, some with running status, the rest noise.
  task automatic random_message();
    bit [7:0] status;
    bit [6:0] vel;
    int       pick;
    if ($urandom_range(0, 9) < 2) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    status = 8'h00;
    if ($urandom_range(0, 2) != 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)      status = TYPE_NOTE_ON | 8'($urandom_range(0, 15));
      else if (pick < 8) status = TYPE_NOTE_OFF | 8'($urandom_range(0, 15));
      else               status = 8'($urandom_range(128, 255));
    end
    vel = ($urandom_range(0, 5) == 0) ? 7'd0 : 7'($urandom_range(0, 127));
    send_note(status, 7'($urandom_range(0, 127)), vel);
  endtask

  // Drain results with random stalls.
  initial begin
    note_event_t got;
    int          gap;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) steady_reader = ~steady_reader;
      gap = steady_reader ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got.is_on = is_note_on_o;
      got.note  = note_number_o;
      got.vel   = note_velocity_o;
      got.band  = band_index_o;
      got.mask  = band_active_mask_o;
      book.check_event(got);
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // data before any status is dropped
    send_byte(8'h45);
    send_byte(8'h00);
    // lowest and highest notes, the top one clamped into the last band
    send_note(TYPE_NOTE_ON, 7'd0, 7'd127);
    send_note(8'h00, 7'd127, 7'd1);
    send_note(TYPE_NOTE_OFF, 7'd0, 7'd0);
    // note-off on an empty band
    send_note(8'h00, 7'd60, 7'd64);
    // zero velocity note-on acts as note-off
    send_note(TYPE_NOTE_ON | 8'h0F, 7'd119, 7'd0);
    // status mid-pair restarts collection; real-time byte does too
    send_byte(TYPE_NOTE_ON | 8'h05);
    send_byte(8'h3C);
    send_byte(8'hF8);
    send_note(TYPE_NOTE_ON | 8'h05, 7'd65, 7'd34);
    // other message types give nothing
    send_note(8'hB3, 7'd7, 7'd127);
    send_note(8'hF0, 7'd18, 7'd52);
    // band edges
    send_note(TYPE_NOTE_ON, 7'd9, 7'd1);
    send_note(8'h00, 7'd10, 7'd2);

    while (bytes_sent < RANDOM_BYTES) random_message();

    // push one band past a full count, then take a few back off
    send_byte(TYPE_NOTE_ON | 8'h03);
    repeat (SATURATE_NOTES) send_note(8'h00, 7'($urandom_range(50, 59)), 7'($urandom_range(1, 127)));
    send_byte(TYPE_NOTE_OFF | 8'h03);
    repeat (4) send_note(8'h00, 7'($urandom_range(50, 59)), 7'($urandom_range(0, 127)));
    repeat (40) random_message();

    push <= 1'b0;
    while (book.owed_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (book.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: midi_note_band_tracker.f
+incdir+rtl
rtl/mnbt_pkg.sv
rtl/mnbt_front.sv
rtl/mnbt_evq.sv
rtl/mnbt_back.sv
rtl/midi_note_band_tracker.sv
dv/midi_note_band_tracker_tb.sv
